@@ rtl/core/tdk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdk_pkg
// Shared constants, codes and types of the time-of-day keeper.
// ----------------------------------------------------------------------------
package tdk_pkg;

    localparam int SUBSEC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSEC_PER_SECOND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_WINDOW      = 8'd1;

    // one fifth of subsec_per_second: x/5 == (x * 52429) >> 18 for any 16-bit x
    localparam int FIFTH_W     = 14;
    localparam int FIFTH_SHIFT = 18;
    localparam int PROD_W      = 34;
    localparam logic [17:0] FIFTH_RECIP = 18'd52429;
    localparam logic [FIFTH_W-1:0] FIFTH_RST  = 14'd6553;
    localparam logic [31:0]        WINDOW_RST = 32'd21600;

    // 5 Hz threshold: fifth * phase
    localparam int THR_W = FIFTH_W + 3;

    localparam logic [2:0] PULSES_PER_SECOND = 3'd5;
    localparam logic [2:0] PHASE_MAX         = 3'd7;
    localparam logic [6:0] SECONDS_PER_MINUTE = 7'd60;
    localparam logic [6:0] MINUTES_PER_HOUR   = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY      = 6'd24;

    // item kind (travels in tuser)
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // RTC status codes; the spare code behaves as no RTC
    localparam logic [1:0] RTC_VALID   = 2'd0;
    localparam logic [1:0] RTC_NONE    = 2'd1;
    localparam logic [1:0] RTC_NO_TIME = 2'd2;

    typedef struct packed {
        logic [FIFTH_W-1:0] fifth;
        logic [31:0]        window;
    } tdk_cfg_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tdk_time_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic       rtc_write_req;
        logic       time_valid;
        logic       day_carry;
        logic [5:0] second_now;
        logic [5:0] minute_now;
        logic [4:0] hour_now;
        logic [31:0] uptime_seconds;
        logic [7:0] count_5hz;
        logic       pulse_5hz;
        logic       pulse_1hz;
    } tdk_result_t;

    localparam int OUT_BITS = $bits(tdk_result_t);
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

@@ rtl/core/tdk_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdk_cfg
// Configuration registers; keeps one fifth of the subsecond rate ready.
// ----------------------------------------------------------------------------
module tdk_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tdk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdk_pkg::CFG_DATA_W-1:0] cfg_data,
    output tdk_pkg::tdk_cfg_t              cfg
);
    import tdk_pkg::*;

    logic [FIFTH_W-1:0] fifth_reg;
    logic [FIFTH_W-1:0] fifth_next;
    logic [31:0]        window_reg;
    logic [31:0]        window_next;
    logic [PROD_W-1:0]  fifth_prod;
    logic               wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    // divide by five through the reciprocal; exact over the whole 16-bit range
    assign fifth_prod = {18'd0, cfg_data[15:0]} * {16'd0, FIFTH_RECIP};

    always_comb
    begin
        fifth_next  = fifth_reg;
        window_next = window_reg;
        if (wr)
        begin
            case (cfg_index)
                CFG_SUBSEC_PER_SECOND: fifth_next  = fifth_prod[FIFTH_SHIFT +: FIFTH_W];
                CFG_VALID_WINDOW:      window_next = cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifth_reg  <= FIFTH_RST;
            window_reg <= WINDOW_RST;
        end
        else
        begin
            fifth_reg  <= fifth_next;
            window_reg <= window_next;
        end
    end

    assign cfg.fifth  = fifth_reg;
    assign cfg.window = window_reg;

endmodule

@@ rtl/core/tdk_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdk_step
// Keeper state and the combinational update for one word.
// ----------------------------------------------------------------------------
module tdk_step
#(
    parameter int SUBSEC_BITS = tdk_pkg::SUBSEC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   op,
    input  logic                   second_due,
    input  logic [SUBSEC_BITS-1:0] subsec,
    input  logic [1:0]             rtc_status,
    input  tdk_pkg::tdk_time_t     time_in,
    input  tdk_pkg::tdk_cfg_t      cfg,
    output tdk_pkg::tdk_result_t   result
);
    import tdk_pkg::*;

    localparam int CMP_W = (SUBSEC_BITS > THR_W) ? SUBSEC_BITS : THR_W;

    logic [31:0] uptime_reg, uptime_next;
    logic [31:0] age_reg, age_next;        // uptime minus last valid moment
    logic        valid_reg, valid_next;
    tdk_time_t   time_reg, time_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  lin_reg, lin_next;
    logic [2:0]  owed_reg, owed_next;

    logic [7:0]       adj;
    logic [31:0]      age_inc;
    logic [6:0]       sec_inc;
    logic [6:0]       min_inc;
    logic [5:0]       hour_inc;
    logic             valid_tmp;
    logic [2:0]       phase_base;
    logic [THR_W-1:0] thr;
    logic             p1, p5, carry, wreq;

    // owed counts of six and seven stand for minus two and minus one
    assign adj      = {{5{owed_reg[2] & owed_reg[1]}}, owed_reg};
    assign age_inc  = age_reg + 32'd1;
    assign sec_inc  = {1'b0, time_reg.second} + 7'd1;
    assign min_inc  = {1'b0, time_reg.minute} + 7'd1;
    assign hour_inc = {1'b0, time_reg.hour} + 6'd1;
    // a second restarts the phase before the threshold compare
    assign phase_base = second_due ? 3'd0 : phase_reg;
    assign thr      = THR_W'(cfg.fifth) * THR_W'(phase_base);

    always_comb
    begin
        uptime_next = uptime_reg;
        age_next    = age_reg;
        valid_next  = valid_reg;
        time_next   = time_reg;
        phase_next  = phase_reg;
        lin_next    = lin_reg;
        owed_next   = owed_reg;
        valid_tmp   = valid_reg;
        p1          = 1'b0;
        p5          = 1'b0;
        carry       = 1'b0;
        wreq        = 1'b0;
        if (step)
        begin
            if (op == OP_SET)
            begin
                time_next  = time_in;
                valid_next = 1'b1;
                age_next   = 32'd0;
                wreq       = 1'b1;
            end
            else
            begin
                if (second_due)
                begin
                    uptime_next = uptime_reg + 32'd1;
                    p1          = 1'b1;
                    lin_next    = lin_reg + adj;
                    owed_next   = PULSES_PER_SECOND;
                    phase_next  = 3'd0;
                    if (rtc_status == RTC_VALID)
                    begin
                        time_next  = time_in;
                        valid_next = 1'b1;
                        age_next   = 32'd0;
                    end
                    else
                    begin
                        // self-increment with rollover of out-of-range values
                        if (sec_inc >= SECONDS_PER_MINUTE)
                        begin
                            time_next.second = 6'd0;
                            if (min_inc >= MINUTES_PER_HOUR)
                            begin
                                time_next.minute = 6'd0;
                                if (hour_inc >= HOURS_PER_DAY)
                                begin
                                    time_next.hour = 5'd0;
                                    carry          = 1'b1;
                                end
                                else
                                begin
                                    time_next.hour = hour_inc[4:0];
                                end
                            end
                            else
                            begin
                                time_next.minute = min_inc[5:0];
                            end
                        end
                        else
                        begin
                            time_next.second = sec_inc[5:0];
                        end
                        age_next   = age_inc;
                        valid_tmp  = valid_reg & ~(age_inc > cfg.window);
                        valid_next = valid_tmp;
                        wreq       = valid_tmp & (rtc_status == RTC_NO_TIME);
                    end
                end
                if (CMP_W'(subsec) >= CMP_W'(thr))
                begin
                    p5 = 1'b1;
                    if (phase_next < PHASE_MAX)
                    begin
                        phase_next = phase_next + 3'd1;
                    end
                    lin_next  = lin_next + 8'd1;
                    owed_next = owed_next - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uptime_reg <= '0;
            age_reg    <= '0;
            valid_reg  <= 1'b0;
            time_reg   <= '0;
            phase_reg  <= '0;
            lin_reg    <= '0;
            owed_reg   <= '0;
        end
        else
        begin
            uptime_reg <= uptime_next;
            age_reg    <= age_next;
            valid_reg  <= valid_next;
            time_reg   <= time_next;
            phase_reg  <= phase_next;
            lin_reg    <= lin_next;
            owed_reg   <= owed_next;
        end
    end

    assign result.rtc_write_req  = wreq;
    assign result.time_valid     = valid_next;
    assign result.day_carry      = carry;
    assign result.second_now     = time_next.second;
    assign result.minute_now     = time_next.minute;
    assign result.hour_now       = time_next.hour;
    assign result.uptime_seconds = uptime_next;
    assign result.count_5hz      = lin_next;
    assign result.pulse_5hz      = p5;
    assign result.pulse_1hz      = p1;

endmodule

@@ rtl/core/time_of_day_keeper_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_keeper_top
// Time-of-day keeper: uptime, 1 Hz / 5 Hz pulses and RTC-backed wall time.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per main-loop wakeup: s_tuser is the kind (tick or
//   set time), s_tdata the second-due flag, subsecond count, RTC status and
//   time. m_* returns one result word for every input word, in order.
//   cfg_* writes subsec_per_second (index 0) or valid_window (index 1); it is
//   always ready and is meant to be used while no word is in flight.
// Path: an accepted word waits in the input register, then passes through
//   the update logic into the result register.
// Throughput: one word per cycle while m_tready is high; a word may follow
//   in the very next cycle, and the step logic updates as each word fires.
// Reset: clears all counters, the time of day and the valid flag; config
//   returns to 32768 units per second and a 21600 second window.
// Stall: while m_tready is low the result holds, the input register fills,
//   and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module time_of_day_keeper_top
#(
    parameter int SUBSEC_BITS = tdk_pkg::SUBSEC_BITS_DEF,
    localparam int IN_BITS = SUBSEC_BITS + 20,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // second_due, subsec, rtc_status, hour_value, minute_value, second_value
    input  logic [IN_W-1:0]                s_tdata,
    // op
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pulse_1hz, pulse_5hz, count_5hz, uptime_seconds, hour_now, minute_now,
    // second_now, day_carry, time_valid, rtc_write_req
    output logic [tdk_pkg::OUT_W-1:0]      m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tdk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tdk_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [IN_BITS-1:0] in_data_reg;
    logic              in_op_reg;
    logic              out_valid_reg, out_valid_next;
    tdk_result_t       res_reg;
    tdk_result_t       res;
    tdk_cfg_t          cfg;
    tdk_time_t         time_in;
    logic              fire;
    logic              accept;

    assign fire     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | fire;
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: hold unless a word moves
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
            in_op_reg   <= s_tuser;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign time_in.hour   = in_data_reg[SUBSEC_BITS+3  +: 5];
    assign time_in.minute = in_data_reg[SUBSEC_BITS+8  +: 6];
    assign time_in.second = in_data_reg[SUBSEC_BITS+14 +: 6];

    tdk_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tdk_step
    #(
        .SUBSEC_BITS (SUBSEC_BITS)
    )
    u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (fire),
        .op         (in_op_reg),
        .second_due (in_data_reg[0]),
        .subsec     (in_data_reg[1 +: SUBSEC_BITS]),
        .rtc_status (in_data_reg[SUBSEC_BITS+1 +: 2]),
        .time_in    (time_in),
        .cfg        (cfg),
        .result     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, res_reg};

endmodule

@@ rtl/core/tdk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdk_checker
// Port-level checks of the time-of-day keeper, bound to the top level.
// ----------------------------------------------------------------------------
module tdk_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [tdk_pkg::OUT_W-1:0] m_tdata
);
    import tdk_pkg::*;

    tdk_result_t r;

    assign r = m_tdata[OUT_BITS-1:0];

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a midnight rollover only comes from a second step
    a_carry_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.day_carry |-> r.pulse_1hz)
        else $error("day carry without a second pulse");

    a_carry_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.day_carry |->
            r.hour_now == 5'd0 && r.minute_now == 6'd0 && r.second_now == 6'd0)
        else $error("day carry with time not at midnight");

    // on a tick, a write request needs time still valid
    a_wreq_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.rtc_write_req && r.pulse_1hz |-> r.time_valid)
        else $error("RTC write request with invalid time");

endmodule

bind time_of_day_keeper_top tdk_checker u_tdk_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
